FILE: rtl/core/flpa_pkg.sv
// flpa_pkg: shared types, widths and codes for the free-list page allocator
`timescale 1ns / 1ps
`default_nettype none

package flpa_pkg;

    // default geometry
    localparam int PAGE_BYTES_DEF = 4096;
    localparam int MAX_PAGES_DEF  = 65536;

    // fixed field widths
    localparam int IN_ADDR_W  = 32;
    localparam int OUT_ADDR_W = 28;
    localparam int LIMIT_W    = 29;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 17;
    localparam int CFG_IDX_W  = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};
    localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST  = '0;
    localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST = LIMIT_W'(234881024);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 1'b1;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BAD_FREE = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_POP  = 1'b1
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/free_list_page_allocator_core.sv
// free_list_page_allocator_core: top level of the lifo page-frame allocator
// results: a free or an allocate from an empty list gives its result in the next cycle,
//   a granting allocate reads the link in S_IDLE and registers its result in S_POP
// throughput: one free or empty allocate per cycle while out_ready drains the results;
//   S_POP takes no request while the registered link-memory read of the head returns
// reset: list empty, free count zero, limits to their defaults; the link memory
//   is not cleared and needs no clearing pass, items are taken straight after reset
`timescale 1ns / 1ps
`default_nettype none

module free_list_page_allocator_core #(
    parameter int PAGE_BYTES = flpa_pkg::PAGE_BYTES_DEF,
    parameter int MAX_PAGES  = flpa_pkg::MAX_PAGES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration writes
    input  wire logic                             cfg_we,
    input  wire logic [flpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [flpa_pkg::LIMIT_W-1:0]     cfg_data,
    // request channel
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             opcode,
    input  wire logic [flpa_pkg::IN_ADDR_W-1:0]   page_address,
    // result channel
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic      [flpa_pkg::OUT_ADDR_W-1:0]  granted_address,
    output logic      [flpa_pkg::STATUS_W-1:0]    status,
    output logic      [flpa_pkg::COUNT_W-1:0]     free_pages
);

    import flpa_pkg::*;

    // page index and link widths; a link holds one extra code for the list end
    localparam int IDX_W  = $clog2(MAX_PAGES);
    localparam int LINK_W = $clog2(MAX_PAGES + 1);

    logic [LIMIT_W-1:0] low_limit_reg, low_limit_next;
    logic [LIMIT_W-1:0] high_limit_reg, high_limit_next;

    logic               mem_we;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_addr;
    logic [LINK_W-1:0]  mem_wdata;
    logic [LINK_W-1:0]  mem_rdata;

    // register decode
    always_comb
    begin
        low_limit_next  = low_limit_reg;
        high_limit_next = high_limit_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOW_LIMIT:  low_limit_next  = cfg_data;
                REG_HIGH_LIMIT: high_limit_next = cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_limit_reg  <= LOW_LIMIT_RST;
            high_limit_reg <= HIGH_LIMIT_RST;
        end
        else
        begin
            low_limit_reg  <= low_limit_next;
            high_limit_reg <= high_limit_next;
        end
    end

    // sequencer: push on free in the accept cycle, pop on allocate through the S_POP state
    flpa_ctrl #(
        .PAGE_BYTES (PAGE_BYTES),
        .MAX_PAGES  (MAX_PAGES),
        .IDX_W      (IDX_W),
        .LINK_W     (LINK_W)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .low_limit       (low_limit_reg),
        .high_limit      (high_limit_reg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .page_address    (page_address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .granted_address (granted_address),
        .status          (status),
        .free_pages      (free_pages),
        .mem_we          (mem_we),
        .mem_re          (mem_re),
        .mem_addr        (mem_addr),
        .mem_wdata       (mem_wdata),
        .mem_rdata       (mem_rdata)
    );

    // one next-link entry per page frame
    flpa_link_ram #(
        .DEPTH  (MAX_PAGES),
        .ADDR_W (IDX_W),
        .DATA_W (LINK_W)
    ) u_link_ram (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

FILE: rtl/core/flpa_link_ram.sv
// flpa_link_ram: single-port next-link memory with registered read
`timescale 1ns / 1ps
`default_nettype none

module flpa_link_ram #(
    parameter int DEPTH  = flpa_pkg::MAX_PAGES_DEF,
    parameter int ADDR_W = $clog2(flpa_pkg::MAX_PAGES_DEF),
    parameter int DATA_W = $clog2(flpa_pkg::MAX_PAGES_DEF + 1)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/flpa_ctrl.sv
// flpa_ctrl: request sequencer, head pointer, free count and result register
`timescale 1ns / 1ps
`default_nettype none

module flpa_ctrl #(
    parameter int PAGE_BYTES = flpa_pkg::PAGE_BYTES_DEF,
    parameter int MAX_PAGES  = flpa_pkg::MAX_PAGES_DEF,
    parameter int IDX_W      = $clog2(flpa_pkg::MAX_PAGES_DEF),
    parameter int LINK_W     = $clog2(flpa_pkg::MAX_PAGES_DEF + 1)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [flpa_pkg::LIMIT_W-1:0]      low_limit,
    input  wire logic [flpa_pkg::LIMIT_W-1:0]      high_limit,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              opcode,
    input  wire logic [flpa_pkg::IN_ADDR_W-1:0]    page_address,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [flpa_pkg::OUT_ADDR_W-1:0]   granted_address,
    output logic      [flpa_pkg::STATUS_W-1:0]     status,
    output logic      [flpa_pkg::COUNT_W-1:0]      free_pages,
    output logic                                   mem_we,
    output logic                                   mem_re,
    output logic      [IDX_W-1:0]                  mem_addr,
    output logic      [LINK_W-1:0]                 mem_wdata,
    input  wire logic [LINK_W-1:0]                 mem_rdata
);

    import flpa_pkg::*;

    localparam int PG_SHIFT = $clog2(PAGE_BYTES);
    localparam logic [LINK_W-1:0]    NULL_LINK = LINK_W'(MAX_PAGES);
    localparam logic [IN_ADDR_W-1:0] PAGE_LIM  = IN_ADDR_W'(MAX_PAGES);

    state_t                  state_reg, state_next;
    logic [LINK_W-1:0]       head_reg, head_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_ADDR_W-1:0]   out_addr_reg, out_addr_next;
    status_t                 out_status_reg, out_status_next;

    logic                    accept;
    logic                    is_alloc;
    logic                    head_valid;
    logic                    free_ok;
    logic [IDX_W-1:0]        wr_idx;
    logic [IDX_W+PG_SHIFT-1:0] top_addr;

    assign accept     = in_valid && in_ready;
    assign is_alloc   = (opcode == OP_ALLOC);
    assign head_valid = (head_reg < NULL_LINK);
    assign wr_idx     = IDX_W'(page_address >> PG_SHIFT);
    assign top_addr   = {head_reg[IDX_W-1:0], {PG_SHIFT{1'b0}}};

    // aligned, inside the limits and inside the frame table
    assign free_ok = (page_address[PG_SHIFT-1:0] == '0)
                  && (page_address >= IN_ADDR_W'(low_limit))
                  && (page_address <  IN_ADDR_W'(high_limit))
                  && ((page_address >> PG_SHIFT) < PAGE_LIM);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && is_alloc && head_valid)
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // handshake and memory control
    always_comb
    begin
        in_ready  = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = !out_valid_reg || out_ready;
                mem_we   = accept && !is_alloc && free_ok;
                mem_re   = accept && is_alloc && head_valid;
            end
            S_POP:
            begin
                in_ready = 1'b0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        mem_addr  = mem_we ? wr_idx : head_reg[IDX_W-1:0];
        mem_wdata = head_reg;
    end

    // list and result update
    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;

        if (accept)
        begin
            if (!is_alloc)
            begin
                out_valid_next = 1'b1;
                out_addr_next  = '0;
                if (free_ok)
                begin
                    out_status_next = ST_OK;
                    head_next       = LINK_W'(wr_idx);
                    if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                else
                begin
                    out_status_next = ST_BAD_FREE;
                end
            end
            else if (!head_valid)
            begin
                out_valid_next  = 1'b1;
                out_addr_next   = '0;
                out_status_next = ST_EMPTY;
            end
        end

        // link of the old head arrives from memory
        if (state_reg == S_POP)
        begin
            out_valid_next  = 1'b1;
            out_addr_next   = OUT_ADDR_W'(top_addr);
            out_status_next = ST_OK;
            head_next       = mem_rdata;
            if (count_reg != '0)
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NULL_LINK;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid       = out_valid_reg;
    assign granted_address = out_addr_reg;
    assign status          = out_status_reg;
    assign free_pages      = count_reg;

endmodule

`default_nettype wire
